// ----- sv/tldb_pkg.sv -----
// Shared types and constants for the two-layer depth buffer.
// Used by the channel interfaces, the controller, the datapath and the checker.
// No dependencies.
package tldb_pkg;

    // Default sizes, handed to the top level parameters
    localparam int unsigned MAX_WIDTH_DEF  = 256;
    localparam int unsigned MAX_HEIGHT_DEF = 256;
    localparam int unsigned DEPTH_BITS_DEF = 24;

    // Field widths of the channel words
    localparam int unsigned OP_W    = 2;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COV_W   = 9;
    localparam int unsigned DEPTH_W = 24;
    localparam int unsigned COLOR_W = 4 * CHAN_W;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0]  CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] FRAME_RESET      = 9'd256;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESOLVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Coverage of 1.0 and fully opaque alpha
    localparam logic [COV_W-1:0]  COV_ONE    = 9'd256;
    localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'd255;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture input word and read both layers
        logic exec;        // apply the captured word
        logic clear_step;  // write one entry of the clearing sweep
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;         // captured operation
        logic            clr_last;   // sweep is at the last entry
        logic            out_block;  // result register full and not taken
    } t_sts;

endpackage

// ----- sv/tldb_if.sv -----
// Channel interfaces of the two-layer depth buffer: pixel words in, resolve words out.
// Depends on tldb_pkg.

interface tldb_pix_if;
    logic                            valid;
    logic                            ready;
    logic [tldb_pkg::OP_W-1:0]       op;
    logic [tldb_pkg::POS_W-1:0]      pos_x;
    logic [tldb_pkg::POS_W-1:0]      pos_y;
    logic [tldb_pkg::CHAN_W-1:0]     red;
    logic [tldb_pkg::CHAN_W-1:0]     green;
    logic [tldb_pkg::CHAN_W-1:0]     blue;
    logic [tldb_pkg::CHAN_W-1:0]     alpha;
    logic [tldb_pkg::COV_W-1:0]      coverage;
    logic [tldb_pkg::DEPTH_W-1:0]    depth;

    modport source (
        output valid, op, pos_x, pos_y, red, green, blue, alpha, coverage, depth,
        input  ready
    );
    modport sink (
        input  valid, op, pos_x, pos_y, red, green, blue, alpha, coverage, depth,
        output ready
    );
endinterface

interface tldb_res_if;
    logic                        valid;
    logic                        ready;
    logic [tldb_pkg::CHAN_W-1:0] out_red;
    logic [tldb_pkg::CHAN_W-1:0] out_green;
    logic [tldb_pkg::CHAN_W-1:0] out_blue;
    logic [tldb_pkg::CHAN_W-1:0] out_alpha;
    logic                        from_translucent;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, from_translucent,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, from_translucent,
        output ready
    );
endinterface

// ----- sv/tldb_ctrl.sv -----
// Controller of the two-layer depth buffer: clearing sweep, accept, execute.
// Depends on tldb_pkg.
module tldb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tldb_pkg::t_sts i_sts,
    output tldb_pkg::t_cmd o_cmd
);

    tldb_pkg::t_state r_state;
    tldb_pkg::t_state n_state;

    // State register; reset starts a clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tldb_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tldb_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = tldb_pkg::ST_IDLE;
                end
            end
            tldb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tldb_pkg::ST_EXEC;
                end
            end
            tldb_pkg::ST_EXEC: begin
                if (i_sts.op == tldb_pkg::OP_CLEAR) begin
                    n_state = tldb_pkg::ST_CLEAR;
                end else if (!(i_sts.op == tldb_pkg::OP_RESOLVE && i_sts.out_block)) begin
                    n_state = tldb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tldb_pkg::ST_CLEAR;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd.load       = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.clear_step = 1'b0;
        case (r_state)
            tldb_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            tldb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tldb_pkg::ST_EXEC: begin
                // hold a resolve until the result register frees up
                o_cmd.exec = !(i_sts.op == tldb_pkg::OP_RESOLVE && i_sts.out_block);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/tldb_datapath.sv -----
// Datapath of the two-layer depth buffer: layer memories, update and resolve logic,
// clear pointer, frame registers and result register.
// Depends on tldb_pkg and tldb_if.
module tldb_datapath #(
    parameter int unsigned MAX_WIDTH  = tldb_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = tldb_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned DEPTH_BITS = tldb_pkg::DEPTH_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tldb_pix_if.sink                            i_pix,
    tldb_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [tldb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tldb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  tldb_pkg::t_cmd                      i_cmd,
    output tldb_pkg::t_sts                      o_sts
);

    localparam int unsigned SIZE   = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW     = (SIZE > 1) ? $clog2(SIZE) : 1;
    localparam int unsigned WORD_W = tldb_pkg::COLOR_W + DEPTH_BITS;
    localparam int unsigned CW     = tldb_pkg::CHAN_W;
    localparam logic [DEPTH_BITS-1:0] DEPTH_INF = '1;
    localparam logic [AW-1:0]         LAST_ADDR = AW'(SIZE - 1);

    // Frame registers
    logic [tldb_pkg::CFG_DATA_W-1:0] r_frame_width;
    logic [tldb_pkg::CFG_DATA_W-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= tldb_pkg::FRAME_RESET;
            r_frame_height <= tldb_pkg::FRAME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tldb_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                tldb_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:                    r_frame_height <= r_frame_height;
            endcase
        end
    end

    // Clear pointer: one entry per cycle, back to zero after the last
    logic [AW-1:0] r_clr_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_ptr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_ptr <= (r_clr_ptr == LAST_ADDR) ? '0 : r_clr_ptr + AW'(1);
        end
    end

    // Capture the input word
    logic [tldb_pkg::OP_W-1:0]    r_op;
    logic [tldb_pkg::POS_W-1:0]   r_x;
    logic [tldb_pkg::POS_W-1:0]   r_y;
    logic [CW-1:0]                r_red;
    logic [CW-1:0]                r_green;
    logic [CW-1:0]                r_blue;
    logic [CW-1:0]                r_alpha;
    logic [tldb_pkg::COV_W-1:0]   r_cov;
    logic [tldb_pkg::DEPTH_W-1:0] r_depth;
    logic [AW-1:0]                r_addr;
    logic [AW-1:0]                w_rd_addr;

    assign w_rd_addr = AW'(32'(i_pix.pos_y) * 32'(MAX_WIDTH) + 32'(i_pix.pos_x));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_pix.op;
            r_x     <= i_pix.pos_x;
            r_y     <= i_pix.pos_y;
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
            r_alpha <= i_pix.alpha;
            r_cov   <= i_pix.coverage;
            r_depth <= i_pix.depth;
            r_addr  <= w_rd_addr;
        end
    end

    // Layer memories, word is {color, depth}
    logic [WORD_W-1:0] r_mem_trans [SIZE];
    logic [WORD_W-1:0] r_mem_opq   [SIZE];
    logic [WORD_W-1:0] r_trans_q;
    logic [WORD_W-1:0] r_opq_q;
    logic              w_t_we;
    logic              w_o_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_t_wdata;
    logic [WORD_W-1:0] w_o_wdata;

    always_ff @(posedge i_clk) begin
        if (w_t_we) begin
            r_mem_trans[w_waddr] <= w_t_wdata;
        end
        if (i_cmd.load) begin
            r_trans_q <= r_mem_trans[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_we) begin
            r_mem_opq[w_waddr] <= w_o_wdata;
        end
        if (i_cmd.load) begin
            r_opq_q <= r_mem_opq[w_rd_addr];
        end
    end

    // Update and resolve decisions
    logic                        w_inside;
    logic [tldb_pkg::COV_W-1:0]  w_cov_sat;
    logic                        w_is_trans;
    logic [DEPTH_BITS-1:0]       w_d;
    logic [DEPTH_BITS-1:0]       w_td;
    logic [DEPTH_BITS-1:0]       w_od;
    logic [tldb_pkg::COLOR_W-1:0] w_tc;
    logic [tldb_pkg::COLOR_W-1:0] w_oc;
    logic                        w_t_front;
    logic                        w_o_front;
    logic [CW+tldb_pkg::COV_W-1:0] w_prod;
    logic [CW-1:0]               w_new_alpha;
    logic [DEPTH_BITS-1:0]       w_new_td;
    logic                        w_do_write;
    logic                        w_take_t;
    logic                        w_res_load;
    logic [tldb_pkg::COLOR_W-1:0] w_res_color;

    always_comb begin
        w_inside = ({1'b0, r_x} < r_frame_width) && (32'(r_x) < 32'(MAX_WIDTH))
                && ({1'b0, r_y} < r_frame_height) && (32'(r_y) < 32'(MAX_HEIGHT));
        w_cov_sat  = (r_cov > tldb_pkg::COV_ONE) ? tldb_pkg::COV_ONE : r_cov;
        w_is_trans = (w_cov_sat < tldb_pkg::COV_ONE) || (r_alpha < tldb_pkg::ALPHA_FULL);
        w_d        = DEPTH_BITS'(r_depth);
        w_td       = r_trans_q[DEPTH_BITS-1:0];
        w_tc       = r_trans_q[WORD_W-1:DEPTH_BITS];
        w_od       = r_opq_q[DEPTH_BITS-1:0];
        w_oc       = r_opq_q[WORD_W-1:DEPTH_BITS];
        w_t_front  = w_td > w_d;
        w_o_front  = w_od > w_d;
        // first write in front scales alpha by coverage
        w_prod      = {{tldb_pkg::COV_W{1'b0}}, r_alpha} * {{CW{1'b0}}, w_cov_sat};
        w_new_alpha = (w_t_front && (w_td == DEPTH_INF)) ? w_prod[2*CW-1:CW] : r_alpha;
        w_new_td    = w_t_front ? w_d : w_td;
        w_do_write  = i_cmd.exec && (r_op == tldb_pkg::OP_WRITE) && w_inside;
        // ties go to the opaque layer
        w_take_t    = w_od > w_td;
        w_res_color = w_take_t ? w_tc : w_oc;
        w_res_load  = i_cmd.exec && (r_op == tldb_pkg::OP_RESOLVE) && w_inside;
    end

    // Memory write port: clearing sweep or pixel update
    always_comb begin
        if (i_cmd.clear_step) begin
            w_waddr   = r_clr_ptr;
            w_t_we    = 1'b1;
            w_o_we    = 1'b1;
            w_t_wdata = {{tldb_pkg::COLOR_W{1'b0}}, DEPTH_INF};
            w_o_wdata = {{tldb_pkg::COLOR_W{1'b0}}, DEPTH_INF};
        end else begin
            w_waddr   = r_addr;
            w_t_we    = w_do_write && w_is_trans;
            w_o_we    = w_do_write && !w_is_trans && w_o_front;
            w_t_wdata = {r_red, r_green, r_blue, w_new_alpha, w_new_td};
            w_o_wdata = {r_red, r_green, r_blue, r_alpha, w_d};
        end
    end

    // Result register
    logic          r_out_valid;
    logic [CW-1:0] r_out_red;
    logic [CW-1:0] r_out_green;
    logic [CW-1:0] r_out_blue;
    logic [CW-1:0] r_out_alpha;
    logic          r_out_trans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_red   <= w_res_color[4*CW-1:3*CW];
            r_out_green <= w_res_color[3*CW-1:2*CW];
            r_out_blue  <= w_res_color[2*CW-1:CW];
            r_out_alpha <= w_res_color[CW-1:0];
            r_out_trans <= w_take_t;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.out_red          = r_out_red;
    assign o_res.out_green        = r_out_green;
    assign o_res.out_blue         = r_out_blue;
    assign o_res.out_alpha        = r_out_alpha;
    assign o_res.from_translucent = r_out_trans;

    // Status to the controller
    assign o_sts.op        = r_op;
    assign o_sts.clr_last  = (r_clr_ptr == LAST_ADDR);
    assign o_sts.out_block = r_out_valid && !o_res.ready;

endmodule

// ----- sv/two_layer_depth_buffer_core.sv -----
// Top level of the two-layer depth buffer: controller plus datapath.
// Depends on tldb_pkg, tldb_if, tldb_ctrl and tldb_datapath.
//
// Usage:
//   i_pix carries pixel words: write, resolve or clear, with position, color,
//   coverage and depth. o_res carries one word per resolve of a pixel inside
//   the frame. The configuration port sets frame width (index 0) and frame
//   height (index 1); write it only while the block is idle.
// Timing:
//   Both layers are read at the edge that accepts a word and updated from the
//   execute state that follows, so the block takes a new word only after the
//   last one is through; this is set by the registered read of the layer
//   memories ahead of the read-modify-write. A resolve word is loaded into the
//   result register from that execute state, where o_res.valid rises.
// Reset and clear:
//   After reset and after every clear word the block sweeps both layer
//   memories, one entry per cycle, over all MAX_WIDTH * MAX_HEIGHT entries (65536
//   with the defaults), with i_pix.ready low. Configuration writes are taken anyway.
// Stall:
//   The result register holds its word until o_res.ready. Writes and clears go
//   on meanwhile; a resolve waits in execute, with i_pix.ready low, until the
//   register frees.
module two_layer_depth_buffer_core #(
    parameter int unsigned MAX_WIDTH  = tldb_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = tldb_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned DEPTH_BITS = tldb_pkg::DEPTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tldb_pix_if.sink                        i_pix,
    tldb_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [tldb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tldb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tldb_pkg::t_cmd w_cmd;
    tldb_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_pix.ready = w_in_ready;

    tldb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tldb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (i_pix),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );

endmodule

// ----- sv/tldb_checker.sv -----
// Port-level checker for the two-layer depth buffer, bound to the top level.
// Depends on tldb_pkg and two_layer_depth_buffer_core.
module tldb_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tldb_pkg::COLOR_W:0]  i_out_word
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // One word at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("input accepted in back-to-back cycles");

    // A fresh result rises only after an accepted word
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc, 2))
        else $error("result without a matching accepted word");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_word))
        else $error("result word changed while stalled");

endmodule

bind two_layer_depth_buffer_core tldb_checker u_tldb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_word  ({o_res.out_red, o_res.out_green, o_res.out_blue, o_res.out_alpha,
                   o_res.from_translucent})
);

// ----- dv/tb_two_layer_depth_buffer_core.sv -----
// Self-checking testbench for two_layer_depth_buffer_core: drives pixel words, predicts
// resolve words from a shadow copy of both layers and compares them at the result port.
// Depends on tldb_pkg, tldb_if and the core RTL.
module tb_two_layer_depth_buffer_core;

    localparam int unsigned CLK_PERIOD   = 4;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned LAYER_SIZE   = tldb_pkg::MAX_WIDTH_DEF * tldb_pkg::MAX_HEIGHT_DEF;
    localparam int unsigned IDLE_PCT     = 35;
    localparam logic [tldb_pkg::OP_W-1:0]    OP_SPARE  = 2'd3;
    localparam logic [tldb_pkg::DEPTH_W-1:0] DEPTH_INF = '1;

    typedef logic [tldb_pkg::POS_W-1:0]   t_pos;
    typedef logic [tldb_pkg::CHAN_W-1:0]  t_chan;
    typedef logic [tldb_pkg::COV_W-1:0]   t_cov;
    typedef logic [tldb_pkg::DEPTH_W-1:0] t_depth;

    typedef struct packed {
        logic [tldb_pkg::OP_W-1:0]    op;
        logic [tldb_pkg::POS_W-1:0]   pos_x;
        logic [tldb_pkg::POS_W-1:0]   pos_y;
        logic [tldb_pkg::CHAN_W-1:0]  red;
        logic [tldb_pkg::CHAN_W-1:0]  green;
        logic [tldb_pkg::CHAN_W-1:0]  blue;
        logic [tldb_pkg::CHAN_W-1:0]  alpha;
        logic [tldb_pkg::COV_W-1:0]   coverage;
        logic [tldb_pkg::DEPTH_W-1:0] depth;
    } t_pix_word;

    typedef struct packed {
        logic [tldb_pkg::CHAN_W-1:0] red;
        logic [tldb_pkg::CHAN_W-1:0] green;
        logic [tldb_pkg::CHAN_W-1:0] blue;
        logic [tldb_pkg::CHAN_W-1:0] alpha;
        logic                        from_tl;
    } t_res_word;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [tldb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tldb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tldb_pix_if pix_if ();
    tldb_res_if res_if ();

    two_layer_depth_buffer_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow layers and frame size
    logic [tldb_pkg::COLOR_W-1:0]    opq_color [LAYER_SIZE];
    logic [tldb_pkg::DEPTH_W-1:0]    opq_depth [LAYER_SIZE];
    logic [tldb_pkg::COLOR_W-1:0]    tl_color  [LAYER_SIZE];
    logic [tldb_pkg::DEPTH_W-1:0]    tl_depth  [LAYER_SIZE];
    logic [tldb_pkg::CFG_DATA_W-1:0] frame_w;
    logic [tldb_pkg::CFG_DATA_W-1:0] frame_h;

    t_pix_word pixel_q [$];
    t_res_word resolve_q [$];
    t_pix_word cur_word;
    int unsigned err_cnt = 0;

    logic steady      = 1'b0;
    logic hold_armed  = 1'b0;
    logic hold_done   = 1'b0;
    int unsigned hold_cnt = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic wipe_layers();
        for (int unsigned i = 0; i < LAYER_SIZE; i++) begin
            opq_color[i] = '0;
            tl_color[i]  = '0;
            opq_depth[i] = DEPTH_INF;
            tl_depth[i]  = DEPTH_INF;
        end
    endtask

    // Frame limits in use, capped at the layer size
    function automatic int unsigned width_limit();
        return (32'(frame_w) < tldb_pkg::MAX_WIDTH_DEF) ? 32'(frame_w)
                                                        : tldb_pkg::MAX_WIDTH_DEF;
    endfunction

    function automatic int unsigned height_limit();
        return (32'(frame_h) < tldb_pkg::MAX_HEIGHT_DEF) ? 32'(frame_h)
                                                         : tldb_pkg::MAX_HEIGHT_DEF;
    endfunction

    // Update the shadow layers for one accepted word; queue the resolve word it yields
    task automatic apply_pixel_word(input t_pix_word w);
        int unsigned                  wl;
        int unsigned                  hl;
        int unsigned                  addr;
        logic [tldb_pkg::COV_W-1:0]   cov;
        logic [16:0]                  prod;
        logic [tldb_pkg::DEPTH_W-1:0] old_d;
        logic                         tl_front;
        logic [tldb_pkg::COLOR_W-1:0] c;
        t_res_word                    r;
        if (w.op == tldb_pkg::OP_CLEAR) begin
            wipe_layers();
            return;
        end
        wl = width_limit();
        hl = height_limit();
        if (w.op == OP_SPARE || 32'(w.pos_x) >= wl || 32'(w.pos_y) >= hl) begin
            return;
        end
        addr = 32'(w.pos_y) * tldb_pkg::MAX_WIDTH_DEF + 32'(w.pos_x);
        cov  = (w.coverage > tldb_pkg::COV_ONE) ? tldb_pkg::COV_ONE : w.coverage;
        if (w.op == tldb_pkg::OP_WRITE) begin
            if (cov < tldb_pkg::COV_ONE || w.alpha < tldb_pkg::ALPHA_FULL) begin
                // translucent: color always, depth only when in front
                old_d = tl_depth[addr];
                tl_color[addr] = {w.red, w.green, w.blue, w.alpha};
                if (old_d > w.depth) begin
                    tl_depth[addr] = w.depth;
                    if (old_d == DEPTH_INF) begin
                        prod = 17'(w.alpha) * 17'(cov);
                        tl_color[addr][tldb_pkg::CHAN_W-1:0] = prod[15:8];
                    end
                end
            end else if (opq_depth[addr] > w.depth) begin
                opq_depth[addr] = w.depth;
                opq_color[addr] = {w.red, w.green, w.blue, w.alpha};
            end
        end else begin
            // resolve: a depth tie goes to the opaque layer
            tl_front = opq_depth[addr] > tl_depth[addr];
            c = tl_front ? tl_color[addr] : opq_color[addr];
            r = {c, tl_front};
            resolve_q.push_back(r);
        end
    endtask

    task automatic push_word(input logic [tldb_pkg::OP_W-1:0] op, input int unsigned x,
                             input int unsigned y,
                             input logic [tldb_pkg::COLOR_W-1:0] rgba,
                             input int unsigned cov,
                             input logic [tldb_pkg::DEPTH_W-1:0] d);
        t_pix_word w;
        w.op       = op;
        w.pos_x    = t_pos'(x);
        w.pos_y    = t_pos'(y);
        {w.red, w.green, w.blue, w.alpha} = rgba;
        w.coverage = t_cov'(cov);
        w.depth    = d;
        pixel_q.push_back(w);
    endtask

    // Pick a coordinate near the origin, at the frame edge, or anywhere
    function automatic int unsigned pick_coord(input int unsigned lim);
        int unsigned r;
        int unsigned v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = $urandom_range(0, 3);
        end else if (r < 70) begin
            v = (lim == 0) ? $urandom_range(0, 1) : lim - 1 + $urandom_range(0, 1);
        end else begin
            v = $urandom_range(0, 255);
        end
        return (v > 255) ? 255 : v;
    endfunction

    function automatic t_pix_word random_pixel_word();
        t_pix_word   w;
        int unsigned r;
        int unsigned wl;
        int unsigned hl;
        wl = width_limit();
        hl = height_limit();
        r = $urandom_range(0, 99);
        w.op    = (r < 50) ? tldb_pkg::OP_WRITE : (r < 96) ? tldb_pkg::OP_RESOLVE : OP_SPARE;
        w.pos_x = t_pos'(pick_coord(wl));
        w.pos_y = t_pos'(pick_coord(hl));
        w.red   = t_chan'($urandom_range(0, 255));
        w.green = t_chan'($urandom_range(0, 255));
        w.blue  = t_chan'($urandom_range(0, 255));
        w.alpha = ($urandom_range(0, 1) == 0) ? tldb_pkg::ALPHA_FULL
                                              : t_chan'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        w.coverage = (r < 45) ? tldb_pkg::COV_ONE
                   : (r < 60) ? t_cov'($urandom_range(257, 511))
                   : t_cov'($urandom_range(0, 255));
        // favor a few depth levels so ties and overwrites happen often
        r = $urandom_range(0, 99);
        w.depth = (r < 15) ? DEPTH_INF
                : (r < 65) ? t_depth'($urandom_range(0, 7) << 20)
                : t_depth'($urandom_range(0, 24'hFF_FFFF));
        return w;
    endfunction

    // Wait until every word is taken and every resolve word has come back
    task automatic drain();
        while (pixel_q.size() != 0 || pix_if.valid || resolve_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [tldb_pkg::CFG_DATA_W-1:0] w,
                             input logic [tldb_pkg::CFG_DATA_W-1:0] h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tldb_pkg::CFG_FRAME_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= tldb_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        frame_w = w;
        frame_h = h;
    endtask

    task automatic run_random(input int unsigned count, input int clear_at);
        for (int unsigned i = 0; i < count; i++) begin
            if (int'(i) == clear_at) begin
                push_word(tldb_pkg::OP_CLEAR, 0, 0, '0, 0, '0);
            end
            pixel_q.push_back(random_pixel_word());
        end
        drain();
    endtask

    // Drive pixel words; predict each word at the edge that accepts it
    always @(posedge i_clk) begin : pixel_driver
        logic idle;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                apply_pixel_word(cur_word);
            end
            if (!pix_if.valid || pix_if.ready) begin
                idle = !steady && hold_cnt == 0 && $urandom_range(0, 99) < IDLE_PCT;
                if (pixel_q.size() != 0 && !idle) begin
                    cur_word = pixel_q.pop_front();
                    pix_if.valid    <= 1'b1;
                    pix_if.op       <= cur_word.op;
                    pix_if.pos_x    <= cur_word.pos_x;
                    pix_if.pos_y    <= cur_word.pos_y;
                    pix_if.red      <= cur_word.red;
                    pix_if.green    <= cur_word.green;
                    pix_if.blue     <= cur_word.blue;
                    pix_if.alpha    <= cur_word.alpha;
                    pix_if.coverage <= cur_word.coverage;
                    pix_if.depth    <= cur_word.depth;
                end else begin
                    pix_if.valid <= 1'b0;
                end
            end
        end
    end

    // Count the long receiver hold-off once it is armed
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_armed && !hold_done) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Stall the result port at random and during the long hold-off, never during the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_cnt != 0) begin
            res_if.ready <= 1'b0;
        end else if (steady) begin
            res_if.ready <= 1'b1;
        end else begin
            res_if.ready <= $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Compare each resolve word with the oldest prediction
    always @(posedge i_clk) begin : resolve_monitor
        t_res_word got;
        t_res_word want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.out_red, res_if.out_green, res_if.out_blue, res_if.out_alpha,
                   res_if.from_translucent};
            if (resolve_q.size() == 0) begin
                report_error($sformatf("unexpected resolve word %h", got));
            end else begin
                want = resolve_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha ||
                    got.from_tl !== want.from_tl) begin
                    report_error($sformatf(
                        "resolve mismatch: exp rgba %h %h %h %h tl %b, got %h %h %h %h tl %b",
                        want.red, want.green, want.blue, want.alpha, want.from_tl,
                        got.red, got.green, got.blue, got.alpha, got.from_tl));
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb_two_layer_depth_buffer_core: FAIL");
        $finish;
    end

    initial begin
        wipe_layers();
        frame_w = tldb_pkg::FRAME_RESET;
        frame_h = tldb_pkg::FRAME_RESET;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = tldb_pkg::CFG_FRAME_WIDTH;
        i_cfg_data      = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Layer rules on the full frame left by reset
        push_word(tldb_pkg::OP_RESOLVE, 0, 0, '0, 0, '0);
        push_word(tldb_pkg::OP_WRITE, 0, 0, 32'h1122_33FF, 256, 24'h80_0000);
        // first translucent write: alpha scaled by coverage
        push_word(tldb_pkg::OP_WRITE, 0, 0, 32'h4455_66C8, 128, 24'h40_0000);
        push_word(tldb_pkg::OP_RESOLVE, 0, 0, '0, 0, '0);
        push_word(tldb_pkg::OP_WRITE, 0, 0, 32'h7788_99AA, 255, 24'h10_0000);
        // translucent behind: color only
        push_word(tldb_pkg::OP_WRITE, 0, 0, 32'hA0B0_C0FF, 0, 24'hF0_0000);
        push_word(tldb_pkg::OP_RESOLVE, 0, 0, '0, 0, '0);
        // opaque at equal depth is not in front
        push_word(tldb_pkg::OP_WRITE, 0, 0, 32'hDEAD_BEFF, 256, 24'h80_0000);
        push_word(tldb_pkg::OP_RESOLVE, 0, 0, '0, 0, '0);
        // coverage above 1.0 counts as opaque
        push_word(tldb_pkg::OP_WRITE, 0, 0, 32'h0F0F_0FFF, 511, 24'h00_0000);
        push_word(tldb_pkg::OP_RESOLVE, 0, 0, '0, 0, '0);
        // layers tied in depth resolve to opaque
        push_word(tldb_pkg::OP_WRITE, 255, 255, 32'h55AA_55FF, 256, 24'h12_3456);
        push_word(tldb_pkg::OP_WRITE, 255, 255, 32'hAA55_AAFE, 300, 24'h12_3456);
        push_word(tldb_pkg::OP_RESOLVE, 255, 255, '0, 0, '0);
        push_word(tldb_pkg::OP_WRITE, 255, 255, 32'hFFFF_FFFF, 511, DEPTH_INF);
        push_word(tldb_pkg::OP_RESOLVE, 255, 255, '0, 0, '0);
        push_word(OP_SPARE, 170, 85, 32'hFFFF_FFFF, 511, DEPTH_INF);
        push_word(tldb_pkg::OP_WRITE, 1, 1, 32'h0102_0300, 0, DEPTH_INF);
        push_word(tldb_pkg::OP_RESOLVE, 1, 1, '0, 0, '0);
        push_word(tldb_pkg::OP_CLEAR, 0, 0, '0, 0, '0);
        push_word(tldb_pkg::OP_RESOLVE, 0, 0, '0, 0, '0);
        push_word(tldb_pkg::OP_RESOLVE, 255, 255, '0, 0, '0);
        drain();

        // Words outside a small frame are dropped
        set_frame(4, 3);
        push_word(tldb_pkg::OP_WRITE, 4, 0, 32'h1234_56FF, 256, 24'h00_0001);
        push_word(tldb_pkg::OP_RESOLVE, 4, 0, '0, 0, '0);
        push_word(tldb_pkg::OP_RESOLVE, 0, 3, '0, 0, '0);
        push_word(tldb_pkg::OP_WRITE, 3, 2, 32'h6543_21FF, 256, 24'h00_0002);
        push_word(tldb_pkg::OP_RESOLVE, 3, 2, '0, 0, '0);
        push_word(tldb_pkg::OP_RESOLVE, 2, 1, '0, 0, '0);
        drain();

        // Random words over a range of frame sizes
        set_frame(16, 16);
        run_random(90, 45);
        set_frame(1, 1);
        run_random(40, -1);
        set_frame(511, 511);
        run_random(90, -1);
        set_frame(0, 0);
        run_random(25, -1);
        set_frame(256, 7);
        steady <= 1'b1;
        run_random(120, -1);
        steady <= 1'b0;
        set_frame(5, 256);
        hold_armed <= 1'b1;
        run_random(100, -1);
        set_frame(256, 256);
        run_random(85, 40);

        if (resolve_q.size() != 0) begin
            report_error($sformatf("%0d resolve words never came", resolve_q.size()));
        end
        if (err_cnt == 0) begin
            $display("tb_two_layer_depth_buffer_core: PASS");
        end else begin
            $display("tb_two_layer_depth_buffer_core: FAIL");
        end
        $finish;
    end

endmodule
